FILE: rtl/c3sk_pkg.sv
package c3sk_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// Fixed field widths of the stream and register words.
	localparam int ROW_W      = 10;
	localparam int SUM_W      = 13;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_ADDR_W = 2;
	localparam int KSEL_W     = 3;
	localparam int S_DATA_W   = 8;
	localparam int M_DATA_W   = 40;
	localparam int RES_W      = SUM_W + 2 * ROW_W;

	// Register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_SELECT = 2'd1;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST = 11'd640;
	localparam logic [KSEL_W-1:0]     KERNEL_RST      = 3'd0;

	// Kernel codes; unused codes behave as identity.
	localparam logic [KSEL_W-1:0] K_IDENT  = 3'd0;
	localparam logic [KSEL_W-1:0] K_MEAN   = 3'd1;
	localparam logic [KSEL_W-1:0] K_GAUSS  = 3'd2;
	localparam logic [KSEL_W-1:0] K_HSOBEL = 3'd3;
	localparam logic [KSEL_W-1:0] K_VSOBEL = 3'd4;

	// Result queue depth.
	localparam int OQ_DEPTH = 8;

	// Per-pixel tag that follows the window down the pipeline.
	typedef struct packed {
		logic             emit;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
	} meta_t;

endpackage

FILE: rtl/c3sk_ram.sv
module c3sk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/c3sk_window.sv
module c3sk_window
	import c3sk_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  logic [PIXEL_BITS-1:0] pix,
	input  logic                  frame_start,
	input  logic [CFG_DATA_W-1:0] image_width,
	output logic                  emit_s1,
	output logic [PIXEL_BITS-1:0] win_s2 [9],
	output meta_t                 meta_s2
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
	localparam int XW = (CW > ROW_W) ? CW : ROW_W;
	localparam int PB = PIXEL_BITS;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [WW-1:0]    img_x;
	logic [WW-1:0]    eff_w;
	logic [WW-1:0]    col_inc;
	logic             wrap;
	logic [XW-1:0]    col_off;
	logic             collide;

	logic             v_s1;
	logic [PB-1:0]    pix_s1;
	logic [CW-1:0]    col_s1;
	meta_t            meta_s1;
	logic             fwd_s1;
	logic [PB-1:0]    fwd_top_s1;
	logic [PB-1:0]    fwd_mid_s1;
	logic [2*PB-1:0]  rdata;
	logic [PB-1:0]    top_s1;
	logic [PB-1:0]    mid_s1;
	logic [PB-1:0]    wp_q [6];

	// Position of the arriving pixel; a frame start restarts at the origin.
	assign col_cur = frame_start ? '0 : col_q;
	assign row_cur = frame_start ? '0 : row_q;

	// Row length clamped to the supported range.
	assign img_x = WW'(image_width);
	always_comb begin
		priority if (img_x < WW'(3)) begin
			eff_w = WW'(3);
		end else if (img_x > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = img_x;
		end
	end

	assign col_inc = WW'(col_cur) + WW'(1);
	assign wrap    = (col_inc >= eff_w);
	assign col_off = XW'(col_cur) - XW'(2);

	// Column and row counters advance with every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= wrap ? '0 : col_inc[CW-1:0];
			row_q <= wrap ? row_cur + ROW_W'(1) : row_cur;
		end
	end

	// Both line buffers share one entry per column: upper row low, lower row high.
	c3sk_ram #(
		.WIDTH(2 * PB),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1),
		.wdata({pix_s1, mid_s1}),
		.re   (acc),
		.raddr(col_cur),
		.rdata(rdata)
	);

	// A read of the column being written back in the same cycle takes the new data.
	assign collide = v_s1 && (col_s1 == col_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= acc;
			fwd_s1 <= acc && collide;
		end
	end

	// Stage 1 payload, captured as the read is issued.
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1       <= pix;
			col_s1       <= col_cur;
			meta_s1.emit <= (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
			meta_s1.row  <= row_cur - ROW_W'(2);
			meta_s1.col  <= col_off[ROW_W-1:0];
		end
		fwd_top_s1 <= mid_s1;
		fwd_mid_s1 <= pix_s1;
	end

	assign top_s1  = fwd_s1 ? fwd_top_s1 : rdata[PB-1:0];
	assign mid_s1  = fwd_s1 ? fwd_mid_s1 : rdata[2*PB-1:PB];
	assign emit_s1 = v_s1 && meta_s1.emit;

	// Two stored columns of the window shift left by one each pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				wp_q[i] <= '0;
			end
		end else if (v_s1) begin
			wp_q[0] <= wp_q[3];
			wp_q[1] <= wp_q[4];
			wp_q[2] <= wp_q[5];
			wp_q[3] <= top_s1;
			wp_q[4] <= mid_s1;
			wp_q[5] <= pix_s1;
		end
	end

	// Full window in row-major order, handed to the kernel stage.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			win_s2[0] <= wp_q[0];
			win_s2[1] <= wp_q[3];
			win_s2[2] <= top_s1;
			win_s2[3] <= wp_q[1];
			win_s2[4] <= wp_q[4];
			win_s2[5] <= mid_s1;
			win_s2[6] <= wp_q[2];
			win_s2[7] <= wp_q[5];
			win_s2[8] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else begin
			meta_s2.emit <= emit_s1;
			meta_s2.row  <= meta_s1.row;
			meta_s2.col  <= meta_s1.col;
		end
	end

`ifndef NO_ASSERTIONS
	// Forwarded line data only exists while a write-back is under way.
	a_fwd_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("forwarding without a write-back");

	// The column counter never leaves the line buffer.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < WW'(MAX_WIDTH))
		else $error("column counter out of range");
`endif

endmodule

FILE: rtl/c3sk_mac.sv
module c3sk_mac
	import c3sk_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PIXEL_BITS-1:0] win_s2 [9],
	input  meta_t                 meta_s2,
	input  logic [KSEL_W-1:0]     kernel_select,
	output logic                  push,
	output logic [RES_W-1:0]      push_data
);

	localparam int PB = PIXEL_BITS;
	localparam int SW = PB + 5;

	logic signed [SW-1:0] px [9];
	logic signed [SW-1:0] ps [3];
	logic signed [SW-1:0] pw [3];
	logic signed [SW-1:0] df [3];
	logic signed [SW-1:0] rs [3];
	logic signed [SW-1:0] r_s3 [3];
	logic signed [SW-1:0] sum;
	logic [SUM_W-1:0]     sum_w;
	meta_t                meta_s3;

	// Plain, weighted and difference sums of each window row.
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			px[i] = $signed(SW'(win_s2[i]));
		end
		for (int r = 0; r < 3; r++) begin
			ps[r] = px[3*r] + px[3*r+1] + px[3*r+2];
			pw[r] = px[3*r] + (px[3*r+1] <<< 1) + px[3*r+2];
			df[r] = px[3*r+2] - px[3*r];
		end
	end

	// Kernel weights applied row by row.
	always_comb begin
		unique case (kernel_select)
			K_MEAN: begin
				rs[0] = ps[0];
				rs[1] = ps[1];
				rs[2] = ps[2];
			end
			K_GAUSS: begin
				rs[0] = pw[0];
				rs[1] = pw[1] <<< 1;
				rs[2] = pw[2];
			end
			K_HSOBEL: begin
				rs[0] = df[0];
				rs[1] = df[1] <<< 1;
				rs[2] = df[2];
			end
			K_VSOBEL: begin
				rs[0] = -pw[0];
				rs[1] = '0;
				rs[2] = pw[2];
			end
			default: begin
				rs[0] = '0;
				rs[1] = px[4];
				rs[2] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			r_s3[r] <= rs[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
		end else begin
			meta_s3 <= meta_s2;
		end
	end

	// Final sum, wrapped or sign-extended to the result width.
	assign sum = r_s3[0] + r_s3[1] + r_s3[2];

	generate
		if (SW >= SUM_W) begin : g_trunc
			assign sum_w = sum[SUM_W-1:0];
		end else begin : g_ext
			assign sum_w = {{(SUM_W - SW){sum[SW-1]}}, sum};
		end
	endgenerate

	assign push      = meta_s3.emit;
	assign push_data = {meta_s3.col, meta_s3.row, sum_w};

endmodule

FILE: rtl/c3sk_outq.sv
module c3sk_outq
	import c3sk_pkg::*;
#(
	parameter int DW    = RES_W,
	parameter int DEPTH = OQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [DW-1:0]              push_data,
	input  logic                       pop,
	output logic                       valid,
	output logic [DW-1:0]              head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	// Results wait here until the downstream side takes them.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign valid = (count_q != '0);
	assign head  = mem_q[rd_q];
	assign count = count_q;

`ifndef NO_ASSERTIONS
	// The input credit must keep a slot free for every result in flight.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < CW'(DEPTH))
		else $error("result queue overflow");

	// A word taken with nothing arriving frees exactly one slot.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - CW'(1))
		else $error("result queue count slip");
`endif

endmodule

FILE: rtl/conv3x3_selectable_kernel.sv
// A result word reaches m_tdata through the stage-1, window, kernel-sum and queue registers.
// Throughput: one pixel word per clock, set by one line-buffer RAM read and one write-back
// per cycle; s_tready falls only when the results held in the 8-entry result queue and
// those still in the pipeline together claim every queue slot.
// Reset (arst_n low, asynchronous): counters, window, queue and registers clear
// (image_width 640, kernel_select 0); line-buffer RAM contents are not cleared.
module conv3x3_selectable_kernel
	import c3sk_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Pixel stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // [7:0] pixel
	input  logic                  s_tuser,  // [0] frame_start
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,  // [12:0] conv_sum, [22:13] out_row, [32:23] out_col
	// Register writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PB  = PIXEL_BITS;
	localparam int QCW = $clog2(OQ_DEPTH + 1);
	localparam int PW  = QCW + 1;

	logic [CFG_DATA_W-1:0] image_width_q;
	logic [KSEL_W-1:0]     kernel_q;
	logic                  acc;
	logic [PB-1:0]         pix;
	logic                  emit_s1;
	logic [PB-1:0]         win_s2 [9];
	meta_t                 meta_s2;
	logic                  push;
	logic [RES_W-1:0]      push_data;
	logic                  pop;
	logic [RES_W-1:0]      head;
	logic [QCW-1:0]        count;
	logic [PW-1:0]         pending;

	// Register file; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			kernel_q      <= KERNEL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH:   image_width_q <= cfg_data;
				REG_KERNEL_SELECT: kernel_q      <= cfg_data[KSEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Pixel word narrowed or widened to the working pixel width.
	generate
		if (PB == S_DATA_W) begin : g_pix_eq
			assign pix = s_tdata;
		end else if (PB < S_DATA_W) begin : g_pix_lo
			assign pix = s_tdata[PB-1:0];
		end else begin : g_pix_hi
			assign pix = {{(PB - S_DATA_W){1'b0}}, s_tdata};
		end
	endgenerate

	// Credit: every result still in the pipeline owns a queue slot.
	assign pending  = PW'(count) + PW'(emit_s1) + PW'(meta_s2.emit) + PW'(push);
	assign s_tready = (pending < PW'(OQ_DEPTH));
	assign acc      = s_tvalid && s_tready;

	c3sk_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.pix        (pix),
		.frame_start(s_tuser),
		.image_width(image_width_q),
		.emit_s1    (emit_s1),
		.win_s2     (win_s2),
		.meta_s2    (meta_s2)
	);

	c3sk_mac #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.win_s2       (win_s2),
		.meta_s2      (meta_s2),
		.kernel_select(kernel_q),
		.push         (push),
		.push_data    (push_data)
	);

	assign pop = m_tvalid && m_tready;

	c3sk_outq #(
		.DW   (RES_W),
		.DEPTH(OQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.valid    (m_tvalid),
		.head     (head),
		.count    (count)
	);

	assign m_tdata = {{(M_DATA_W - RES_W){1'b0}}, head};

endmodule
